// ===== sv/v3a_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, operation and status codes, types and helpers of the vector ALU.
package v3a_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int OPND_W        = 34;
    localparam int PROD_W        = 2 * OPND_W;
    localparam int WIDE_W        = 70;
    localparam int SQRT_LAT      = 32;
    localparam int DIV_QB        = 33;
    localparam int SIDE_LEN      = SQRT_LAT + DIV_QB + 2;

    // operation codes
    localparam logic [3:0] FN_ADD   = 4'd0;
    localparam logic [3:0] FN_SUB   = 4'd1;
    localparam logic [3:0] FN_SCALE = 4'd2;
    localparam logic [3:0] FN_DOT   = 4'd3;
    localparam logic [3:0] FN_CROSS = 4'd4;
    localparam logic [3:0] FN_EQ    = 4'd5;
    localparam logic [3:0] FN_NEG   = 4'd6;
    localparam logic [3:0] FN_LEN   = 4'd7;
    localparam logic [3:0] FN_LENSQ = 4'd8;
    localparam logic [3:0] FN_DIV   = 4'd9;
    localparam logic [3:0] FN_ISZ   = 4'd10;
    localparam logic [3:0] FN_NORM  = 4'd11;
    localparam logic [3:0] FN_DIST  = 4'd12;
    localparam logic [3:0] FN_NE    = 4'd13;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_word WORD_MAX = 32'sh7FFFFFFF;
    localparam t_word WORD_MIN = 32'sh80000000;
    localparam t_wide WIDE_MAX = 70'sd2147483647;
    localparam t_wide WIDE_MIN = -70'sd2147483648;

    typedef struct packed {
        t_word val;
        logic  ovf;
    } t_sat;

    // operands of one word as they enter the lanes
    typedef struct packed {
        logic [3:0]  func;
        t_word [2:0] a;
        t_word       s;
    } t_carry;

    // what one lane hands to the merge stage
    typedef struct packed {
        t_prod                p0;
        t_prod                p1;
        logic signed [WORD_W:0] simp;
        logic                 eq;
        logic                 zr;
        logic                 dov;
    } t_lane;

    // partial result riding alongside the root and divider pipelines
    typedef struct packed {
        logic [3:0]  func;
        t_word [2:0] a;
        t_word       s;
        t_word [2:0] vec;
        logic [2:0]  vsat;
        t_word       scal;
        logic        ssat;
        logic        flag;
        logic        dov;
        logic        div0;
        logic        keep;
        logic [2:0]  qneg;
    } t_side;

    // clamp a wide signed value to one word
    function automatic t_sat sat_word(input t_wide v);
        t_sat r;
        if (v > WIDE_MAX) begin
            r.val = WORD_MAX;
            r.ovf = 1'b1;
        end else if (v < WIDE_MIN) begin
            r.val = WORD_MIN;
            r.ovf = 1'b1;
        end else begin
            r.val = v[WORD_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== sv/v3a_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the vector ALU: operation code, two vectors and a scalar.
interface v3a_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale;

    modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scale, input ready);
    modport sink   (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scale, output ready);
endinterface

// ===== sv/v3a_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the vector ALU: vector, scalar, flag and status.
interface v3a_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_scalar;
    logic               r_flag;
    logic [1:0]         status;

    modport source (output valid, r_x, r_y, r_z, r_scalar, r_flag, status, input ready);
    modport sink   (input valid, r_x, r_y, r_z, r_scalar, r_flag, status, output ready);
endinterface

// ===== sv/v3a_lane.sv =====
`timescale 1ns / 1ps
// One component lane: operand selection, add/sub/negate, compares and two multipliers.
module v3a_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [3:0]      i_func,
    input  v3a_pkg::t_word  i_a,
    input  v3a_pkg::t_word  i_b,
    input  v3a_pkg::t_word  i_s,
    input  v3a_pkg::t_word  i_c0a,
    input  v3a_pkg::t_word  i_c0b,
    input  v3a_pkg::t_word  i_c1a,
    input  v3a_pkg::t_word  i_c1b,
    output v3a_pkg::t_lane  o_res
);
    import v3a_pkg::*;

    logic signed [WORD_W:0]   w_d;
    logic signed [WORD_W:0]   n_simp, r_simp;
    logic signed [OPND_W-1:0] n_o0a, n_o0b, n_o1a, n_o1b;
    logic signed [OPND_W-1:0] r_o0a, r_o0b, r_o1a, r_o1b;
    logic                     n_eq, n_zr, n_dov, r_eq, r_zr, r_dov;
    t_lane                    r_out;

    // difference, exact in one extra bit
    assign w_d = $signed({i_a[WORD_W-1], i_a}) - $signed({i_b[WORD_W-1], i_b});

    // operand and simple result selection
    always_comb begin
        n_simp = '0;
        n_o0a  = '0;
        n_o0b  = '0;
        n_o1a  = '0;
        n_o1b  = '0;
        case (i_func)
            FN_ADD:   n_simp = $signed({i_a[WORD_W-1], i_a}) + $signed({i_b[WORD_W-1], i_b});
            FN_SUB:   n_simp = w_d;
            FN_NEG:   n_simp = -$signed({i_a[WORD_W-1], i_a});
            FN_SCALE: begin
                n_o0a = OPND_W'(i_a);
                n_o0b = OPND_W'(i_s);
            end
            FN_DOT: begin
                n_o0a = OPND_W'(i_a);
                n_o0b = OPND_W'(i_b);
            end
            FN_CROSS: begin
                n_o0a = OPND_W'(i_c0a);
                n_o0b = OPND_W'(i_c0b);
                n_o1a = OPND_W'(i_c1a);
                n_o1b = OPND_W'(i_c1b);
            end
            FN_LEN, FN_LENSQ, FN_NORM: begin
                n_o0a = OPND_W'(i_a);
                n_o0b = OPND_W'(i_a);
            end
            FN_DIST: begin
                n_o0a = OPND_W'(w_d);
                n_o0b = OPND_W'(w_d);
            end
            default: ;
        endcase
        n_eq  = (i_a == i_b);
        n_zr  = (i_a == '0);
        n_dov = (w_d[WORD_W] != w_d[WORD_W-1]);
    end

    // operand stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o0a  <= n_o0a;
            r_o0b  <= n_o0b;
            r_o1a  <= n_o1a;
            r_o1b  <= n_o1b;
            r_simp <= n_simp;
            r_eq   <= n_eq;
            r_zr   <= n_zr;
            r_dov  <= n_dov;
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.p0   <= r_o0a * r_o0b;
            r_out.p1   <= r_o1a * r_o1b;
            r_out.simp <= r_simp;
            r_out.eq   <= r_eq;
            r_out.zr   <= r_zr;
            r_out.dov  <= r_dov;
        end
    end

    assign o_res = r_out;
endmodule

// ===== sv/v3a_sqrt.sv =====
`timescale 1ns / 1ps
// Integer square root of a 64-bit value, one result bit per pipeline stage.
module v3a_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_n,
    output logic [31:0] o_res
);
    import v3a_pkg::*;

    logic [63:0] r_rem  [SQRT_LAT];
    logic [63:0] r_root [SQRT_LAT];

    for (genvar j = 0; j < SQRT_LAT; j++) begin : g_stg
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] w_rem, w_root, w_try;

        if (j == 0) begin : g_first
            assign w_rem  = i_n;
            assign w_root = '0;
        end else begin : g_next
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
        end

        assign w_try = w_root + BIT;

        // try this bit, keep it if the remainder allows
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem >= w_try) begin
                    r_rem[j]  <= w_rem - w_try;
                    r_root[j] <= (w_root >> 1) + BIT;
                end else begin
                    r_rem[j]  <= w_rem;
                    r_root[j] <= w_root >> 1;
                end
            end
        end
    end

    assign o_res = r_root[SQRT_LAT-1][31:0];
endmodule

// ===== sv/v3a_div.sv =====
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per stage, with an overflow flag.
module v3a_div #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [v3a_pkg::WORD_W+FRAC_BITS-1:0]  i_n,
    input  logic [v3a_pkg::WORD_W-1:0]            i_d,
    output logic [v3a_pkg::DIV_QB-1:0]            o_q,
    output logic                                  o_big
);
    import v3a_pkg::*;

    localparam int NUM_W = WORD_W + FRAC_BITS;
    localparam int TOP_W = NUM_W - DIV_QB;

    logic [WORD_W-1:0] r_rem [DIV_QB];
    logic [DIV_QB-1:0] r_nlo [DIV_QB];
    logic [WORD_W-1:0] r_d   [DIV_QB];
    logic [DIV_QB-1:0] r_q   [DIV_QB];
    logic              r_big [DIV_QB];

    for (genvar j = 0; j < DIV_QB; j++) begin : g_stg
        logic [WORD_W-1:0] w_rem, w_d;
        logic [DIV_QB-1:0] w_nlo, w_q;
        logic              w_big;
        logic [WORD_W:0]   w_sh, w_sub;

        if (j == 0) begin : g_first
            // quotient of 2^33 or more only needs to be flagged
            assign w_rem = {{(WORD_W - TOP_W){1'b0}}, i_n[NUM_W-1:DIV_QB]};
            assign w_nlo = i_n[DIV_QB-1:0];
            assign w_d   = i_d;
            assign w_q   = '0;
            assign w_big = (w_rem >= i_d);
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_nlo = r_nlo[j-1];
            assign w_d   = r_d[j-1];
            assign w_q   = r_q[j-1];
            assign w_big = r_big[j-1];
        end

        assign w_sh  = {w_rem, w_nlo[DIV_QB-1-j]};
        assign w_sub = w_sh - {1'b0, w_d};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nlo[j] <= w_nlo;
                r_d[j]   <= w_d;
                r_big[j] <= w_big;
                if (w_sh >= {1'b0, w_d}) begin
                    r_rem[j] <= w_sub[WORD_W-1:0];
                    r_q[j]   <= {w_q[DIV_QB-2:0], 1'b1};
                end else begin
                    r_rem[j] <= w_sh[WORD_W-1:0];
                    r_q[j]   <= {w_q[DIV_QB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_q   = r_q[DIV_QB-1];
    assign o_big = r_big[DIV_QB-1];
endmodule

// ===== sv/vector3_alu.sv =====
`timescale 1ns / 1ps
// Top level of the three-component fixed-point vector ALU.
// The block takes one word per cycle unless the output stalls, and gives one result word
// per input word, in order, through an input register, two lane stages (operands, then
// products), a merge stage, a 32-stage square-root pipeline, a divider setup stage,
// 33-stage divider lanes and an output register. Every operation goes the full length,
// so results never reorder. The whole pipeline advances together; while a result waits
// at the output, input is taken only if the output register is free or being emptied.
// Values are signed Q16.16 by default (FRAC_BITS fraction bits); out-of-range results
// clamp and report status 2, divide by zero returns vector a with status 1.
module vector3_alu #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    v3a_in_if.sink           i_in,
    v3a_out_if.source        o_out
);
    import v3a_pkg::*;

    localparam int NUM_W   = WORD_W + FRAC_BITS;
    localparam int VLD_LEN = SIDE_LEN + 4;

    logic               w_en;
    logic [VLD_LEN-1:0] r_vld;
    t_carry             r_c1, r_c2, r_c3;
    t_lane              w_lane [3];
    t_side              n_side, n_pside;
    t_side              r_side [SIDE_LEN];
    logic [63:0]        n_sq, r_sq;
    logic [31:0]        w_root;
    logic [NUM_W-1:0]   n_num [3];
    logic [NUM_W-1:0]   r_num [3];
    logic [WORD_W-1:0]  n_dd, r_dd;
    logic [DIV_QB-1:0]  w_q   [3];
    logic               w_big [3];
    t_word              n_ov [3];
    t_word              r_ov [3];
    t_word              n_os, r_os;
    logic               n_of, r_of;
    logic [1:0]         n_ost, r_ost;

    // whole pipeline moves unless the output word is stuck
    assign w_en        = !r_vld[VLD_LEN-1] || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_vld[VLD_LEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VLD_LEN-2:0], i_in.valid};
        end
    end

    // input register and operand carry through the lane stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1.func <= i_in.func;
            r_c1.a[0] <= i_in.a_x;
            r_c1.a[1] <= i_in.a_y;
            r_c1.a[2] <= i_in.a_z;
            r_c1.s    <= i_in.scale;
            r_c2      <= r_c1;
            r_c3      <= r_c2;
        end
    end

    logic [WORD_W-1:0] r_b1 [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1[0] <= i_in.b_x;
            r_b1[1] <= i_in.b_y;
            r_b1[2] <= i_in.b_z;
        end
    end

    // component lanes
    for (genvar l = 0; l < 3; l++) begin : g_lane
        v3a_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_func (r_c1.func),
            .i_a    (r_c1.a[l]),
            .i_b    (r_b1[l]),
            .i_s    (r_c1.s),
            .i_c0a  (r_c1.a[(l + 1) % 3]),
            .i_c0b  (r_b1[(l + 2) % 3]),
            .i_c1a  (r_c1.a[(l + 2) % 3]),
            .i_c1b  (r_b1[(l + 1) % 3]),
            .o_res  (w_lane[l])
        );
    end

    // merge: per-lane vector results, dot and squared sum, flags
    always_comb begin
        t_wide w_v;
        t_wide w_sum;
        t_sat  w_s;
        n_side      = '0;
        n_side.func = r_c3.func;
        n_side.a    = r_c3.a;
        n_side.s    = r_c3.s;
        for (int l = 0; l < 3; l++) begin
            case (r_c3.func)
                FN_ADD, FN_SUB, FN_NEG: w_v = t_wide'(w_lane[l].simp);
                FN_SCALE:               w_v = t_wide'(w_lane[l].p0) >>> FRAC_BITS;
                FN_CROSS: w_v = (t_wide'(w_lane[l].p0) - t_wide'(w_lane[l].p1)) >>> FRAC_BITS;
                default:                w_v = '0;
            endcase
            w_s              = sat_word(w_v);
            n_side.vec[l]    = w_s.val;
            n_side.vsat[l]   = w_s.ovf;
        end
        w_sum = t_wide'(w_lane[0].p0) + t_wide'(w_lane[1].p0) + t_wide'(w_lane[2].p0);
        w_s   = sat_word(w_sum >>> FRAC_BITS);
        if (r_c3.func == FN_DOT || r_c3.func == FN_LENSQ) begin
            n_side.scal = w_s.val;
            n_side.ssat = w_s.ovf;
        end
        case (r_c3.func)
            FN_EQ:   n_side.flag = w_lane[0].eq & w_lane[1].eq & w_lane[2].eq;
            FN_NE:   n_side.flag = ~(w_lane[0].eq & w_lane[1].eq & w_lane[2].eq);
            FN_ISZ:  n_side.flag = w_lane[0].zr & w_lane[1].zr & w_lane[2].zr;
            default: n_side.flag = 1'b0;
        endcase
        n_side.dov = w_lane[0].dov | w_lane[1].dov | w_lane[2].dov;
        n_sq       = w_sum[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq <= n_sq;
        end
    end

    v3a_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_n   (r_sq),
        .o_res (w_root)
    );

    // divider setup: length results, divisor choice, magnitudes and signs
    always_comb begin
        t_side       w_ps;
        logic        w_div, w_norm;
        logic [31:0] w_am;
        w_ps    = r_side[SQRT_LAT];
        n_pside = w_ps;
        w_div   = (w_ps.func == FN_DIV);
        w_norm  = (w_ps.func == FN_NORM);
        n_pside.div0 = w_div && (w_ps.s == '0);
        n_pside.keep = (w_div && (w_ps.s == '0)) || (w_norm && (w_root == '0));
        if (w_ps.func == FN_LEN || w_ps.func == FN_DIST) begin
            if ((w_ps.func == FN_DIST && w_ps.dov) || w_root[31]) begin
                n_pside.scal = WORD_MAX;
                n_pside.ssat = 1'b1;
            end else begin
                n_pside.scal = w_root;
                n_pside.ssat = 1'b0;
            end
        end
        n_dd = w_div ? (w_ps.s[WORD_W-1] ? 32'd0 - w_ps.s : w_ps.s) : w_root;
        for (int l = 0; l < 3; l++) begin
            w_am            = w_ps.a[l][WORD_W-1] ? 32'd0 - w_ps.a[l] : w_ps.a[l];
            n_num[l]        = {w_am, {FRAC_BITS{1'b0}}};
            n_pside.qneg[l] = w_ps.a[l][WORD_W-1] ^ (w_div & w_ps.s[WORD_W-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dd <= n_dd;
            for (int l = 0; l < 3; l++) begin
                r_num[l] <= n_num[l];
            end
        end
    end

    // partial results ride alongside root and divider
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= (k == SQRT_LAT + 1) ? n_pside : r_side[k-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_div
        v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_n   (r_num[l]),
            .i_d   (r_dd),
            .o_q   (w_q[l]),
            .o_big (w_big[l])
        );
    end

    // final select, quotient clamp and status
    always_comb begin
        t_side w_os;
        logic  w_sat;
        logic  w_ovf;
        w_os  = r_side[SIDE_LEN-1];
        w_sat = w_os.ssat;
        w_ovf = 1'b0;
        for (int l = 0; l < 3; l++) begin
            if (w_os.func == FN_DIV || w_os.func == FN_NORM) begin
                if (w_os.keep) begin
                    n_ov[l] = w_os.a[l];
                end else if (w_os.qneg[l]) begin
                    w_ovf   = w_big[l] || (w_q[l] > 33'h080000000);
                    n_ov[l] = w_ovf ? WORD_MIN : t_word'(~w_q[l][WORD_W-1:0] + 32'd1);
                    w_sat   = w_sat | w_ovf;
                end else begin
                    w_ovf   = w_big[l] || w_q[l][DIV_QB-1] || w_q[l][WORD_W-1];
                    n_ov[l] = w_ovf ? WORD_MAX : t_word'(w_q[l][WORD_W-1:0]);
                    w_sat   = w_sat | w_ovf;
                end
            end else begin
                n_ov[l] = w_os.vec[l];
                w_sat   = w_sat | w_os.vsat[l];
            end
        end
        n_os = w_os.scal;
        n_of = w_os.flag;
        if (w_sat) begin
            n_ost = ST_SAT;
        end else if (w_os.div0) begin
            n_ost = ST_DIV0;
        end else begin
            n_ost = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ov  <= n_ov;
            r_os  <= n_os;
            r_of  <= n_of;
            r_ost <= n_ost;
        end
    end

    assign o_out.r_x      = r_ov[0];
    assign o_out.r_y      = r_ov[1];
    assign o_out.r_z      = r_ov[2];
    assign o_out.r_scalar = r_os;
    assign o_out.r_flag   = r_of;
    assign o_out.status   = r_ost;
endmodule

// ===== sv/v3a_check.sv =====
`timescale 1ns / 1ps
// Port-level checker for the vector ALU and its bind to the top level.
module v3a_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_r_x,
    input logic [31:0] i_r_y,
    input logic [31:0] i_r_z,
    input logic [31:0] i_r_scalar,
    input logic        i_r_flag,
    input logic [1:0]  i_status
);
    import v3a_pkg::*;

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its x component, scalar and status
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_r_x) && $stable(i_r_scalar)
                                         && $stable(i_status))
        else $error("result payload changed while stalled");

    // an empty output register never blocks the input
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with output empty");

    // a set flag comes with no other field set
    a_flag_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_r_flag |-> i_r_x == '0 && i_r_y == '0 && i_r_z == '0
                                    && i_r_scalar == '0 && i_status == ST_OK)
        else $error("flag result with other fields set");
endmodule

bind vector3_alu v3a_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_r_x       (o_out.r_x),
    .i_r_y       (o_out.r_y),
    .i_r_z       (o_out.r_z),
    .i_r_scalar  (o_out.r_scalar),
    .i_r_flag    (o_out.r_flag),
    .i_status    (o_out.status)
);

// ===== test/vector3_alu_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the three-component fixed-point vector ALU.
module vector3_alu_test;
    import v3a_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct {
        logic [3:0]  func;
        t_word       ax, ay, az, bx, by, bz, s;
    } t_op;

    typedef struct {
        t_word       rx, ry, rz, sc;
        logic        flag;
        logic [1:0]  st;
        logic        fixed;     // typed-in expectation
    } t_res;

    // directed row: operands plus optional typed-in result
    typedef struct {
        t_op  op;
        t_res res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    v3a_in_if  in_ch ();
    v3a_out_if out_ch ();

    vector3_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_res   results_due[$];
    int     mismatches;
    int     phase;          // 0 none, 1 sender idle, 2 receiver stall, 3 both
    logic   hold_off;       // long receiver hold-off
    logic   sending_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor arithmetic
    // ---------------------------------------------------------------
    function automatic logic signed [69:0] clamp(input logic signed [69:0] v,
                                                 inout logic [1:0] st);
        if (v > 70'sd2147483647) begin
            st = ST_SAT;
            return 70'sd2147483647;
        end
        if (v < -70'sd2147483648) begin
            st = ST_SAT;
            return -70'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] root_floor(input logic [69:0] n);
        logic [69:0] rem, res, bit_v;
        rem = n;
        res = '0;
        bit_v = 70'd1 << 68;
        while (bit_v > rem) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res[63:0];
    endfunction

    function automatic logic signed [69:0] mag_sq(input logic signed [69:0] x,
                                                  input logic signed [69:0] y,
                                                  input logic signed [69:0] z);
        return x * x + y * y + z * z;
    endfunction

    // (x << FB) / d, truncated toward zero, clipped far past the word range
    function automatic logic signed [69:0] fx_div(input logic signed [69:0] x,
                                                  input logic signed [69:0] d);
        logic [69:0] n, q;
        logic neg;
        n = (x < 0 ? -x : x) << FB;
        q = n / (d < 0 ? -d : d);
        neg = (x < 0) != (d < 0);
        if (q > (70'd1 << 40)) q = 70'd1 << 40;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_res predict_alu(input t_op op);
        t_res r;
        logic signed [69:0] a [3], b [3], v [3], d [3], sc, s;
        logic [63:0] len;
        logic has_vec, has_sc, oor;
        r = '{default: 0};
        a[0] = 70'(op.ax); a[1] = 70'(op.ay); a[2] = 70'(op.az);
        b[0] = 70'(op.bx); b[1] = 70'(op.by); b[2] = 70'(op.bz);
        s = 70'(op.s);
        v = '{0, 0, 0};
        sc = 0;
        has_vec = 1'b0;
        has_sc = 1'b0;
        case (op.func)
            FN_ADD: begin
                for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
                has_vec = 1'b1;
            end
            FN_SUB: begin
                for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
                has_vec = 1'b1;
            end
            FN_SCALE: begin
                for (int i = 0; i < 3; i++) v[i] = (a[i] * s) >>> FB;
                has_vec = 1'b1;
            end
            FN_DOT: begin
                sc = (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FB;
                has_sc = 1'b1;
            end
            FN_CROSS: begin
                v[0] = (a[1] * b[2] - a[2] * b[1]) >>> FB;
                v[1] = (a[2] * b[0] - a[0] * b[2]) >>> FB;
                v[2] = (a[0] * b[1] - a[1] * b[0]) >>> FB;
                has_vec = 1'b1;
            end
            FN_EQ, FN_NE: begin
                r.flag = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
                if (op.func == FN_NE) r.flag = ~r.flag;
            end
            FN_NEG: begin
                for (int i = 0; i < 3; i++) v[i] = -a[i];
                has_vec = 1'b1;
            end
            FN_LEN: begin
                sc = 70'(root_floor(mag_sq(a[0], a[1], a[2])));
                has_sc = 1'b1;
            end
            FN_LENSQ: begin
                sc = mag_sq(a[0], a[1], a[2]) >>> FB;
                has_sc = 1'b1;
            end
            FN_DIV: begin
                if (s == 0) begin
                    v = a;
                    r.st = ST_DIV0;
                end else begin
                    for (int i = 0; i < 3; i++) v[i] = fx_div(a[i], s);
                end
                has_vec = 1'b1;
            end
            FN_ISZ: r.flag = (a[0] == 0) && (a[1] == 0) && (a[2] == 0);
            FN_NORM: begin
                len = root_floor(mag_sq(a[0], a[1], a[2]));
                for (int i = 0; i < 3; i++)
                    v[i] = (len == 0) ? a[i] : fx_div(a[i], $signed({6'd0, len}));
                has_vec = 1'b1;
            end
            FN_DIST: begin
                oor = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    d[i] = a[i] - b[i];
                    if (d[i] > 70'sd2147483647 || d[i] < -70'sd2147483648) oor = 1'b1;
                end
                sc = oor ? 70'sd2147483648 : 70'(root_floor(mag_sq(d[0], d[1], d[2])));
                has_sc = 1'b1;
            end
            default: ;
        endcase
        if (has_vec) begin
            r.rx = t_word'(clamp(v[0], r.st));
            r.ry = t_word'(clamp(v[1], r.st));
            r.rz = t_word'(clamp(v[2], r.st));
        end
        if (has_sc) r.sc = t_word'(clamp(sc, r.st));
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom_range(0, 3)) - 1;
            1: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
            2: return t_word'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
            3: return t_word'($signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000);
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_op rand_op();
        t_op op;
        op.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(14, 15))
                                               : 4'($urandom_range(0, 13));
        op.ax = rand_word(); op.ay = rand_word(); op.az = rand_word();
        op.bx = rand_word(); op.by = rand_word(); op.bz = rand_word();
        op.s  = rand_word();
        // equal operands now and then so that eq and ne see both outcomes
        if ($urandom_range(0, 3) == 0) begin
            op.bx = op.ax; op.by = op.ay; op.bz = op.az;
        end
        if ($urandom_range(0, 7) == 0) begin
            op.ax = 0; op.ay = 0; op.az = 0;
        end
        if ($urandom_range(0, 7) == 0) op.s = 0;
        return op;
    endfunction

    // drive one word and wait for its acceptance
    task automatic send_word(input t_op op, input t_res typed);
        int idle_pct;
        idle_pct = (phase == 1) ? 80 : (phase == 3) ? 8 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= op.func;
        in_ch.a_x   <= op.ax;
        in_ch.a_y   <= op.ay;
        in_ch.a_z   <= op.az;
        in_ch.b_x   <= op.bx;
        in_ch.b_y   <= op.by;
        in_ch.b_z   <= op.bz;
        in_ch.scale <= op.s;
        results_due.push_back(typed.fixed ? typed : predict_alu(op));
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    localparam t_word ONE = 32'sh10000;

    t_row rows [] = '{
        '{'{FN_ADD, WORD_MAX, 0, 0, 1, 0, 0, 0},
          '{WORD_MAX, 0, 0, 0, 0, ST_SAT, 1}},
        '{'{FN_SUB, WORD_MIN, 0, 0, 1, 0, 0, 0},
          '{WORD_MIN, 0, 0, 0, 0, ST_SAT, 1}},
        '{'{FN_SCALE, ONE, -ONE, WORD_MAX, 0, 0, 0, 2 * ONE}, '{default: 0}},
        '{'{FN_DOT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN, 0},
          '{0, 0, 0, WORD_MIN, 0, ST_SAT, 1}},
        '{'{FN_CROSS, ONE, 0, 0, 0, ONE, 0, 0}, '{0, 0, ONE, 0, 0, ST_OK, 1}},
        '{'{FN_EQ, 5, -7, WORD_MIN, 5, -7, WORD_MIN, 0}, '{0, 0, 0, 0, 1, ST_OK, 1}},
        '{'{FN_NE, 5, -7, WORD_MIN, 5, -7, WORD_MAX, 0}, '{0, 0, 0, 0, 1, ST_OK, 1}},
        '{'{FN_NEG, WORD_MIN, WORD_MAX, 0, 0, 0, 0, 0},
          '{WORD_MAX, -WORD_MAX, 0, 0, 0, ST_SAT, 1}},
        '{'{FN_LEN, 3, 4, 0, 0, 0, 0, 0}, '{0, 0, 0, 5, 0, ST_OK, 1}},
        '{'{FN_LEN, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0}, '{default: 0}},
        '{'{FN_LENSQ, WORD_MAX, WORD_MIN, WORD_MAX, 0, 0, 0, 0},
          '{0, 0, 0, WORD_MAX, 0, ST_SAT, 1}},
        '{'{FN_DIV, 7, WORD_MIN, -1, 0, 0, 0, 0}, '{7, WORD_MIN, -1, 0, 0, ST_DIV0, 1}},
        '{'{FN_DIV, WORD_MAX, WORD_MIN, ONE, 0, 0, 0, 1}, '{default: 0}},
        '{'{FN_DIV, 3 * ONE, -ONE, 0, 0, 0, 0, -2 * ONE}, '{default: 0}},
        '{'{FN_ISZ, 0, 0, 0, 9, 9, 9, 9}, '{0, 0, 0, 0, 1, ST_OK, 1}},
        '{'{FN_ISZ, 0, 0, 1, 0, 0, 0, 0}, '{default: 0}},
        '{'{FN_NORM, 0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, ST_OK, 1}},
        '{'{FN_NORM, 3 * ONE, -4 * ONE, 0, 0, 0, 0, 0}, '{default: 0}},
        '{'{FN_NORM, WORD_MIN, 1, 0, 0, 0, 0, 0}, '{default: 0}},
        '{'{FN_DIST, WORD_MAX, 0, 0, WORD_MIN, 0, 0, 0},
          '{0, 0, 0, WORD_MAX, 0, ST_SAT, 1}},
        '{'{FN_DIST, 3, 0, 4, 0, 0, 0, 0}, '{0, 0, 0, 5, 0, ST_OK, 1}},
        '{'{4'd14, -1, -1, -1, -1, -1, -1, -1}, '{0, 0, 0, 0, 0, ST_OK, 1}},
        '{'{4'd15, -1, -1, -1, 1, 1, 1, 1}, '{0, 0, 0, 0, 0, ST_OK, 1}}
    };

    initial begin
        int wait_cycles;
        phase = 0;
        hold_off = 1'b0;
        sending_done = 1'b0;
        mismatches = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = '0;
        in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0;
        in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0;
        in_ch.scale = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (rows[k]) send_word(rows[k].op, rows[k].res);

        // random words through the four idling phases
        for (int n = 0; n < 950; n++) begin
            phase = (n / 60) % 4;
            if (n == 500) hold_off = 1'b1;
            send_word(rand_op(), '{default: 0});
        end
        in_ch.valid <= 1'b0;
        phase = 0;
        sending_done = 1'b1;

        wait_cycles = 0;
        while (results_due.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // long receiver hold-off, counted here while the sender keeps offering
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        wait (hold_off);
        while (stall_cycles < 300) begin
            @(posedge i_clk);
            stall_cycles++;
        end
        hold_off = 1'b0;
    end

    // receiver ready
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if (phase == 2 && !sending_done)
                out_ch.ready <= ($urandom_range(0, 99) >= 80);
            else if (phase == 3 && !sending_done)
                out_ch.ready <= ($urandom_range(0, 99) >= 8);
            else
                out_ch.ready <= 1'b1;
        end
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                exp_r = results_due.pop_front();
                if (out_ch.r_x !== exp_r.rx || out_ch.r_y !== exp_r.ry
                    || out_ch.r_z !== exp_r.rz || out_ch.r_scalar !== exp_r.sc
                    || out_ch.r_flag !== exp_r.flag || out_ch.status !== exp_r.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %h %b %d got %h %h %h %h %b %d",
                                 exp_r.rx, exp_r.ry, exp_r.rz, exp_r.sc, exp_r.flag,
                                 exp_r.st, out_ch.r_x, out_ch.r_y, out_ch.r_z,
                                 out_ch.r_scalar, out_ch.r_flag, out_ch.status);
                end
            end
        end
    end

endmodule

// ===== sim.f =====
sv/v3a_pkg.sv
sv/v3a_in_if.sv
sv/v3a_out_if.sv
sv/v3a_lane.sv
sv/v3a_sqrt.sv
sv/v3a_div.sv
sv/vector3_alu.sv
sv/v3a_check.sv
test/vector3_alu_test.sv
